// ===== rtl/core/itpu_pkg.sv =====
// ----------------------------------------------------------------------------
// itpu_pkg
// Shared types and constants of the interrupt, timer and protection unit.
// ----------------------------------------------------------------------------
package itpu_pkg;

  localparam int unsigned CFG_AW = 5;

  // configuration register indexes
  localparam logic [2:0] CFG_SLOW_TICK  = 3'd0;
  localparam logic [2:0] CFG_FAST_TICK  = 3'd1;
  localparam logic [2:0] CFG_CNT_PERIOD = 3'd2;
  localparam logic [2:0] CFG_WD_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_PANEL_ID   = 3'd4;

  localparam logic [23:0] SLOW_TICK_RST  = 24'd1920000;
  localparam logic [19:0] FAST_TICK_RST  = 20'd232727;
  localparam logic [7:0]  CNT_PERIOD_RST = 8'd15;
  localparam logic [23:0] WD_PERIOD_RST  = 24'd1920000;
  localparam logic [2:0]  PANEL_ID_RST   = 3'd0;

  // operations
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_MEMCHK = 3'd3;
  localparam logic [2:0] OP_LINE   = 3'd4;
  localparam logic [2:0] OP_ACK    = 3'd5;

  // register offsets, bit 0 cleared
  localparam logic [4:0] OFF_STATUS   = 5'h02;
  localparam logic [4:0] OFF_PENDING  = 5'h06;
  localparam logic [4:0] OFF_MASK     = 5'h08;
  localparam logic [4:0] OFF_CLR_TICK = 5'h0C;
  localparam logic [4:0] OFF_CLR_CNT  = 5'h0E;
  localparam logic [4:0] OFF_WD_CLR   = 5'h10;
  localparam logic [4:0] OFF_COUNTER  = 5'h12;
  localparam logic [4:0] OFF_PROTECT  = 5'h14;
  localparam logic [4:0] OFF_PROT_HI  = 5'h16;
  localparam logic [4:0] OFF_PROT_LO  = 5'h18;

  localparam logic [1:0] LINE_EXT_NMI = 2'd3;

  localparam logic [6:0]  VEC_BASE    = 7'h78;
  localparam logic [7:0]  SRC_TICK    = 8'h01;
  localparam logic [7:0]  SRC_COUNTER = 8'h20;
  localparam logic [15:0] RD_UNMAPPED = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  reg_offset;
    logic [15:0] write_data;
    logic [19:0] mem_address;
    logic [1:0]  line_select;
    logic        line_level;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  irq_vector;
    logic        irq_out;
    logic        nmi_out;
    logic        overflow_out;
    logic        write_trapped;
  } out_word_t;

  typedef struct packed {
    logic [23:0] slow_tick_period;
    logic [19:0] fast_tick_period;
    logic [7:0]  counter_period;
    logic [23:0] watchdog_period;
    logic [2:0]  panel_id;
  } cfg_t;

endpackage

// ===== rtl/core/itpu_apb.sv =====
// ----------------------------------------------------------------------------
// itpu_apb
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module itpu_apb
  import itpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_tick_period <= SLOW_TICK_RST;
      cfg_r.fast_tick_period <= FAST_TICK_RST;
      cfg_r.counter_period   <= CNT_PERIOD_RST;
      cfg_r.watchdog_period  <= WD_PERIOD_RST;
      cfg_r.panel_id         <= PANEL_ID_RST;
    end else if (wr_en) begin
      unique case (idx)
        CFG_SLOW_TICK:  cfg_r.slow_tick_period <= pwdata[23:0];
        CFG_FAST_TICK:  cfg_r.fast_tick_period <= pwdata[19:0];
        CFG_CNT_PERIOD: cfg_r.counter_period   <= pwdata[7:0];
        CFG_WD_PERIOD:  cfg_r.watchdog_period  <= pwdata[23:0];
        CFG_PANEL_ID:   cfg_r.panel_id         <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_SLOW_TICK:  prdata = {8'd0, cfg_r.slow_tick_period};
      CFG_FAST_TICK:  prdata = {12'd0, cfg_r.fast_tick_period};
      CFG_CNT_PERIOD: prdata = {24'd0, cfg_r.counter_period};
      CFG_WD_PERIOD:  prdata = {8'd0, cfg_r.watchdog_period};
      CFG_PANEL_ID:   prdata = {29'd0, cfg_r.panel_id};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/itpu_core.sv =====
// ----------------------------------------------------------------------------
// itpu_core
// Controller state and the step that applies one word to it.
// ----------------------------------------------------------------------------
module itpu_core
  import itpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_word_t  item,
  output out_word_t res
);

  logic [7:0]  status_lo_r, status_lo_nxt;
  logic        wd_nmi_r, wd_nmi_nxt;
  logic        ext_nmi_r, ext_nmi_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [15:0] down_r, down_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic        ovf_r, ovf_nxt;
  logic [1:0]  wdt_r, wdt_nxt;
  logic        prot_on_r, prot_on_nxt;
  logic [19:0] prot_lo_r, prot_lo_nxt;
  logic [19:0] prot_hi_r, prot_hi_nxt;
  logic [23:0] tick_left_r, tick_left_nxt;
  logic [7:0]  cnt_left_r, cnt_left_nxt;
  logic [23:0] wd_left_r, wd_left_nxt;
  logic        irq_r, irq_nxt;
  logic        nmi_r, nmi_nxt;

  logic [23:0] slow_p, fast_p, wd_p;
  logic [7:0]  cnt_p;
  logic [15:0] down_dec;
  logic [1:0]  wdt_inc;
  logic [4:0]  off;
  logic [19:0] addr;
  logic [7:0]  line_bit;
  logic [7:0]  active;
  logic [15:0] rd;
  logic        trap;
  logic        upd;
  logic [6:0]  vec;

  assign slow_p   = (cfg.slow_tick_period == '0) ? 24'd1 : cfg.slow_tick_period;
  assign fast_p   = (cfg.fast_tick_period == '0) ? 24'd1 : {4'd0, cfg.fast_tick_period};
  assign cnt_p    = (cfg.counter_period == '0) ? 8'd1 : cfg.counter_period;
  assign wd_p     = (cfg.watchdog_period == '0) ? 24'd1 : cfg.watchdog_period;
  assign down_dec = down_r - 16'd1;
  assign wdt_inc  = wdt_r + 2'd1;
  assign off      = {item.reg_offset[4:1], 1'b0};
  assign addr     = {item.mem_address[19:1], 1'b0};
  assign line_bit = 8'h04 << item.line_select;

  always_comb begin
    status_lo_nxt = status_lo_r;
    wd_nmi_nxt    = wd_nmi_r;
    ext_nmi_nxt   = ext_nmi_r;
    pend_nxt      = pend_r;
    mask_nxt      = mask_r;
    down_nxt      = down_r;
    reload_nxt    = reload_r;
    ovf_nxt       = ovf_r;
    wdt_nxt       = wdt_r;
    prot_on_nxt   = prot_on_r;
    prot_lo_nxt   = prot_lo_r;
    prot_hi_nxt   = prot_hi_r;
    tick_left_nxt = tick_left_r;
    cnt_left_nxt  = cnt_left_r;
    wd_left_nxt   = wd_left_r;
    rd            = 16'd0;
    trap          = 1'b0;
    upd           = 1'b0;

    unique case (item.operation)
      OP_TICK: begin
        if (tick_left_r <= 24'd1) begin
          tick_left_nxt = status_lo_r[1] ? fast_p : slow_p;
          pend_nxt      = pend_nxt | SRC_TICK;
          upd           = 1'b1;
        end else begin
          tick_left_nxt = tick_left_r - 24'd1;
        end
        if (cnt_left_r <= 8'd1) begin
          cnt_left_nxt = cnt_p;
          down_nxt     = down_dec;
          if (down_dec == 16'd0) begin
            ovf_nxt  = ~ovf_r;
            pend_nxt = pend_nxt | SRC_COUNTER;
            upd      = 1'b1;
          end else if (down_dec == 16'hFFFF && status_lo_r[0]) begin
            down_nxt = reload_r;
          end
        end else begin
          cnt_left_nxt = cnt_left_r - 8'd1;
        end
        if (wd_left_r <= 24'd1) begin
          wd_left_nxt = wd_p;
          wdt_nxt     = wdt_inc;
          if (wdt_inc == 2'd3) begin
            wd_nmi_nxt = 1'b1;
            upd        = 1'b1;
          end
        end else begin
          wd_left_nxt = wd_left_r - 24'd1;
        end
      end
      OP_READ: begin
        unique case (off)
          OFF_STATUS:  rd = {cfg.panel_id[1:0], 4'd0, ext_nmi_r, wd_nmi_r, status_lo_r};
          OFF_PENDING: rd = {8'd0, pend_r & mask_r};
          OFF_MASK:    rd = {8'd0, mask_r};
          OFF_COUNTER: rd = down_r;
          OFF_PROTECT: begin
            prot_on_nxt = 1'b0;
            rd          = 16'd0;
          end
          default:     rd = RD_UNMAPPED;
        endcase
      end
      OP_WRITE: begin
        unique case (off)
          OFF_STATUS: begin
            status_lo_nxt = item.write_data[7:0];
            if (item.write_data[1] != status_lo_r[1]) begin
              tick_left_nxt = item.write_data[1] ? fast_p : slow_p;
            end
          end
          OFF_MASK: begin
            mask_nxt = item.write_data[7:0];
            upd      = 1'b1;
          end
          OFF_CLR_TICK: begin
            pend_nxt = pend_r & ~SRC_TICK;
            upd      = 1'b1;
          end
          OFF_CLR_CNT: begin
            pend_nxt = pend_r & ~SRC_COUNTER;
            upd      = 1'b1;
          end
          OFF_WD_CLR:  wdt_nxt = 2'd0;
          OFF_COUNTER: begin
            reload_nxt = item.write_data;
            down_nxt   = item.write_data;
          end
          OFF_PROTECT: prot_on_nxt = 1'b1;
          OFF_PROT_HI: prot_hi_nxt = {item.write_data, 4'hF};
          OFF_PROT_LO: prot_lo_nxt = {item.write_data, 4'h0};
          default: ;
        endcase
      end
      OP_MEMCHK: begin
        if (prot_on_r && (addr <= prot_lo_r || addr > prot_hi_r)) begin
          trap = 1'b1;
        end
      end
      OP_LINE: begin
        if (item.line_select == LINE_EXT_NMI) begin
          ext_nmi_nxt = item.line_level;
        end else if (item.line_level) begin
          pend_nxt = pend_r | line_bit;
        end else begin
          pend_nxt = pend_r & ~line_bit;
        end
        upd = 1'b1;
      end
      default: ;
    endcase

    active = pend_nxt & mask_nxt;
    if (upd || trap) begin
      irq_nxt = |active;
      nmi_nxt = wd_nmi_nxt || ext_nmi_nxt || trap;
    end else begin
      irq_nxt = irq_r;
      nmi_nxt = nmi_r;
    end
  end

  // lowest pending unmasked source wins
  always_comb begin
    vec = VEC_BASE;
    for (int i = 7; i >= 0; i--) begin
      if (active[i]) vec = VEC_BASE + 7'(i);
    end
  end

  assign res.read_data     = rd;
  assign res.irq_vector    = vec;
  assign res.irq_out       = irq_nxt;
  assign res.nmi_out       = nmi_nxt;
  assign res.overflow_out  = ovf_nxt;
  assign res.write_trapped = trap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_lo_r <= '0;
      wd_nmi_r    <= 1'b0;
      ext_nmi_r   <= 1'b0;
      pend_r      <= '0;
      mask_r      <= '0;
      down_r      <= '0;
      reload_r    <= '0;
      ovf_r       <= 1'b0;
      wdt_r       <= '0;
      prot_on_r   <= 1'b0;
      prot_lo_r   <= '0;
      prot_hi_r   <= '0;
      tick_left_r <= SLOW_TICK_RST;
      cnt_left_r  <= CNT_PERIOD_RST;
      wd_left_r   <= WD_PERIOD_RST;
      irq_r       <= 1'b0;
      nmi_r       <= 1'b0;
    end else if (step) begin
      status_lo_r <= status_lo_nxt;
      wd_nmi_r    <= wd_nmi_nxt;
      ext_nmi_r   <= ext_nmi_nxt;
      pend_r      <= pend_nxt;
      mask_r      <= mask_nxt;
      down_r      <= down_nxt;
      reload_r    <= reload_nxt;
      ovf_r       <= ovf_nxt;
      wdt_r       <= wdt_nxt;
      prot_on_r   <= prot_on_nxt;
      prot_lo_r   <= prot_lo_nxt;
      prot_hi_r   <= prot_hi_nxt;
      tick_left_r <= tick_left_nxt;
      cnt_left_r  <= cnt_left_nxt;
      wd_left_r   <= wd_left_nxt;
      irq_r       <= irq_nxt;
      nmi_r       <= nmi_nxt;
    end
  end

endmodule

// ===== rtl/core/interrupt_timer_protection_unit.sv =====
// ----------------------------------------------------------------------------
// interrupt_timer_protection_unit
// Interrupt controller, tick timer, down-counter, watchdog and write
// protection of a handheld system controller.
// ----------------------------------------------------------------------------
// Each input word (tick, register access, memory write check, line change or
// acknowledge) is captured in an input register, applied to the controller
// state by itpu_core, and its result word is held in an output register; a
// word moves from the input register to the output register once the output
// register is empty or being taken. One word is accepted per clock as long as
// the result side keeps up; the state update in itpu_core sets that rate.
// in_stall rises only when both the input and the output register hold a word
// and out_stall is high.
// Configuration registers take effect on the next word; write them while the
// unit is idle. There is no clearing pass after reset.
module interrupt_timer_protection_unit
  import itpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  in_word_t  in_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_word_t out_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t res;
  logic      advance;
  logic      take;
  logic      step;

  itpu_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  itpu_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (in_r),
    .res   (res)
  );

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign step      = s1_valid_r && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s1_valid_nxt  = take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
    out_valid_nxt = step ? 1'b1 : (advance ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_r <= in_data;
    if (step) out_r <= res;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output stage can move");

  a_no_irq_base_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.irq_out) |-> (out_data.irq_vector == VEC_BASE))
    else $error("vector points at a source while irq is low");

  a_trap_raises_nmi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.write_trapped) |-> out_data.nmi_out)
    else $error("trapped write without nmi");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for interrupt_timer_protection_unit. A directed table
// and then random words go in with random idle gaps and result stalls; each
// result word is checked field by field against the table (typed rows) or
// an in-bench model of the interrupt, timer and protection state. Period and
// panel registers are written over APB between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import itpu_pkg::*;

  localparam logic [2:0]  OP_SPARE     = 3'd7;
  localparam logic [4:0]  OFF_SEL      = 5'h1E;
  localparam logic [4:0]  OFF_UNMAPPED = 5'h1F;
  localparam logic [19:0] ADDR_KEEP    = 20'hFFFFE;
  localparam logic [1:0]  LINE_EXT_B   = 2'd0;
  localparam logic [1:0]  LINE_EXT_A   = 2'd1;
  localparam logic [1:0]  LINE_COMP    = 2'd2;
  localparam logic [15:0] ST_PERIODIC  = 16'h0001;
  localparam logic [15:0] ST_FAST      = 16'h0002;
  localparam logic [15:0] ST_WD_NMI    = 16'h0100;
  localparam logic [15:0] ST_EXT_NMI   = 16'h0200;

  typedef struct packed {
    logic      typed;
    out_word_t res;
    in_word_t  word;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  interrupt_timer_protection_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // model state
  cfg_t        cfg;
  logic [15:0] st_reg;
  logic [7:0]  pend;
  logic [7:0]  msk;
  logic [15:0] dcount;
  logic [15:0] reload;
  logic        ovf;
  logic [1:0]  wd_ticks;
  logic        prot_on;
  logic [19:0] prot_lo;
  logic [19:0] prot_hi;
  logic [23:0] tick_left;
  logic [7:0]  cnt_left;
  logic [23:0] wd_left;
  logic        irq_lvl;
  logic        nmi_lvl;

  out_word_t due_results[$];
  dir_row_t  dir_tab[$];
  int        mismatches = 0;
  logic      calm = 1'b0;

  task automatic report(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [23:0] nonzero_period(input logic [23:0] p);
    return (p == 24'd0) ? 24'd1 : p;
  endfunction

  function automatic logic [23:0] tick_period();
    logic [23:0] p;
    p = ((st_reg & ST_FAST) != 16'd0) ? {4'd0, cfg.fast_tick_period} : cfg.slow_tick_period;
    return nonzero_period(p);
  endfunction

  function void refresh_lines(input logic trap);
    irq_lvl = ((pend & msk) != 8'd0);
    nmi_lvl = ((st_reg & (ST_WD_NMI | ST_EXT_NMI)) != 16'd0) || trap;
  endfunction

  function automatic logic [6:0] vector_now();
    logic [7:0] p;
    logic [6:0] v;
    int i;
    p = pend & msk;
    v = VEC_BASE;
    for (i = 7; i >= 0; i--) if (p[i]) v = VEC_BASE + i[6:0];
    return v;
  endfunction

  function void model_reset();
    cfg.slow_tick_period = SLOW_TICK_RST;
    cfg.fast_tick_period = FAST_TICK_RST;
    cfg.counter_period = CNT_PERIOD_RST;
    cfg.watchdog_period = WD_PERIOD_RST;
    cfg.panel_id = PANEL_ID_RST;
    st_reg = '0; pend = '0; msk = '0; dcount = '0; reload = '0; ovf = 1'b0;
    wd_ticks = '0; prot_on = 1'b0; prot_lo = '0; prot_hi = '0;
    irq_lvl = 1'b0; nmi_lvl = 1'b0;
    tick_left = nonzero_period(SLOW_TICK_RST);
    cnt_left = (CNT_PERIOD_RST == 8'd0) ? 8'd1 : CNT_PERIOD_RST;
    wd_left = nonzero_period(WD_PERIOD_RST);
  endfunction

  function void bus_cycle();
    if (tick_left <= 24'd1) begin
      tick_left = tick_period();
      pend = pend | SRC_TICK;
      refresh_lines(1'b0);
    end else begin
      tick_left = tick_left - 24'd1;
    end
    if (cnt_left <= 8'd1) begin
      cnt_left = (cfg.counter_period == 8'd0) ? 8'd1 : cfg.counter_period;
      dcount = dcount - 16'd1;
      if (dcount == 16'd0) begin
        ovf = ~ovf;
        pend = pend | SRC_COUNTER;
        refresh_lines(1'b0);
      end else if (dcount == 16'hFFFF && (st_reg & ST_PERIODIC) != 16'd0) begin
        dcount = reload;
      end
    end else begin
      cnt_left = cnt_left - 8'd1;
    end
    if (wd_left <= 24'd1) begin
      wd_left = nonzero_period(cfg.watchdog_period);
      wd_ticks = wd_ticks + 2'd1;
      if (wd_ticks == 2'd3) begin
        st_reg = st_reg | ST_WD_NMI;
        refresh_lines(1'b0);
      end
    end else begin
      wd_left = wd_left - 24'd1;
    end
  endfunction

  function automatic logic [15:0] reg_read(input logic [4:0] off);
    case (off & OFF_SEL)
      OFF_STATUS:  return st_reg | {cfg.panel_id[1:0], 14'd0};
      OFF_PENDING: return {8'd0, pend & msk};
      OFF_MASK:    return {8'd0, msk};
      OFF_COUNTER: return dcount;
      OFF_PROTECT: begin
        prot_on = 1'b0;
        return 16'd0;
      end
      default:     return RD_UNMAPPED;
    endcase
  endfunction

  function automatic void reg_write(input logic [4:0] off, input logic [15:0] data);
    logic rate_flip;
    case (off & OFF_SEL)
      OFF_STATUS: begin
        rate_flip = ((data ^ st_reg) & ST_FAST) != 16'd0;
        st_reg = {st_reg[15:8], data[7:0]};
        if (rate_flip) tick_left = tick_period();
      end
      OFF_MASK: begin
        msk = data[7:0];
        refresh_lines(1'b0);
      end
      OFF_CLR_TICK: begin
        pend = pend & ~SRC_TICK;
        refresh_lines(1'b0);
      end
      OFF_CLR_CNT: begin
        pend = pend & ~SRC_COUNTER;
        refresh_lines(1'b0);
      end
      OFF_WD_CLR:  wd_ticks = '0;
      OFF_COUNTER: begin
        reload = data;
        dcount = data;
      end
      OFF_PROTECT: prot_on = 1'b1;
      OFF_PROT_HI: prot_hi = {data, 4'hF};
      OFF_PROT_LO: prot_lo = {data, 4'h0};
      default: ;
    endcase
  endfunction

  function automatic void line_change(input logic [1:0] sel, input logic lvl);
    logic [7:0] bit_sel;
    if (sel == LINE_EXT_NMI) begin
      if (lvl) st_reg = st_reg | ST_EXT_NMI;
      else st_reg = st_reg & ~ST_EXT_NMI;
    end else begin
      bit_sel = 8'h04 << sel;
      if (lvl) pend = pend | bit_sel;
      else pend = pend & ~bit_sel;
    end
    refresh_lines(1'b0);
  endfunction

  function automatic out_word_t unit_response(input in_word_t w);
    out_word_t r;
    logic [19:0] addr;
    r = '0;
    case (w.operation)
      OP_TICK:  bus_cycle();
      OP_READ:  r.read_data = reg_read(w.reg_offset);
      OP_WRITE: reg_write(w.reg_offset, w.write_data);
      OP_MEMCHK: begin
        addr = w.mem_address & ADDR_KEEP;
        if (prot_on && (addr <= prot_lo || addr > prot_hi)) begin
          refresh_lines(1'b1);
          r.write_trapped = 1'b1;
        end
      end
      OP_LINE:  line_change(w.line_select, w.line_level);
      default: ;
    endcase
    r.irq_vector = vector_now();
    r.irq_out = irq_lvl;
    r.nmi_out = nmi_lvl;
    r.overflow_out = ovf;
    return r;
  endfunction

  function automatic in_word_t word_of(input logic [2:0] op, input logic [4:0] off,
                                       input logic [15:0] data, input logic [19:0] addr,
                                       input logic [1:0] sel, input logic lvl);
    in_word_t w;
    w.operation = op;
    w.reg_offset = off;
    w.write_data = data;
    w.mem_address = addr;
    w.line_select = sel;
    w.line_level = lvl;
    return w;
  endfunction

  function automatic out_word_t res_of(input logic [15:0] rd, input logic [6:0] vec,
                                       input logic irq, input logic nmi,
                                       input logic trap);
    out_word_t r;
    r.read_data = rd;
    r.irq_vector = vec;
    r.irq_out = irq;
    r.nmi_out = nmi;
    r.overflow_out = 1'b0;
    r.write_trapped = trap;
    return r;
  endfunction

  function void add_row(input logic typed, input out_word_t r, input in_word_t w);
    dir_tab.push_back({typed, r, w});
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int pick;
    w.operation = 3'($urandom_range(0, 7));
    w.reg_offset = 5'($urandom_range(0, 31));
    w.write_data = 16'($urandom_range(0, 65535));
    w.mem_address = 20'($urandom_range(0, 1048575));
    w.line_select = 2'($urandom_range(0, 3));
    w.line_level = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.operation = OP_TICK;
    end else if (pick < 50) begin
      w.operation = OP_READ;
    end else if (pick < 66) begin
      w.operation = OP_WRITE;
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: w.reg_offset = OFF_STATUS;
          1: w.reg_offset = OFF_PENDING;
          2: w.reg_offset = OFF_MASK;
          3: w.reg_offset = OFF_CLR_TICK;
          4: w.reg_offset = OFF_CLR_CNT;
          5: w.reg_offset = OFF_WD_CLR;
          6: w.reg_offset = OFF_COUNTER;
          7: w.reg_offset = OFF_PROTECT;
          8: w.reg_offset = OFF_PROT_HI;
          default: w.reg_offset = OFF_PROT_LO;
        endcase
        w.reg_offset[0] = 1'($urandom_range(0, 1));
      end
      // short reloads so the counter reaches zero often
      if ((w.reg_offset & OFF_SEL) == OFF_COUNTER && $urandom_range(0, 3) != 0)
        w.write_data = 16'($urandom_range(0, 40));
    end else if (pick < 78) begin
      w.operation = OP_MEMCHK;
      case ($urandom_range(0, 3))
        2: w.mem_address = 20'(prot_lo - 20'd1 + $urandom_range(0, 3));
        3: w.mem_address = 20'(prot_hi - 20'd1 + $urandom_range(0, 3));
        default: ;
      endcase
    end else if (pick < 90) begin
      w.operation = OP_LINE;
    end else if (pick < 95) begin
      w.operation = OP_ACK;
    end else begin
      w.operation = 3'($urandom_range(6, 7));
    end
    return w;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    int gap;
    out_word_t got;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    got = unit_response(w);
    due_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] keep;
    case (idx)
      CFG_SLOW_TICK: begin
        keep = val & 32'h00FF_FFFF;
        cfg.slow_tick_period = keep[23:0];
      end
      CFG_FAST_TICK: begin
        keep = val & 32'h000F_FFFF;
        cfg.fast_tick_period = keep[19:0];
      end
      CFG_CNT_PERIOD: begin
        keep = val & 32'h0000_00FF;
        cfg.counter_period = keep[7:0];
      end
      CFG_WD_PERIOD: begin
        keep = val & 32'h00FF_FFFF;
        cfg.watchdog_period = keep[23:0];
      end
      default: begin
        keep = val & 32'h0000_0007;
        cfg.panel_id = keep[2:0];
      end
    endcase
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== keep)
      report($sformatf("cfg reg %0d reads %h, want %h", idx, prdata, keep));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int n);
    case (n)
      0: begin
        cfg_write(CFG_SLOW_TICK, 32'd7);
        cfg_write(CFG_FAST_TICK, 32'd3);
        cfg_write(CFG_CNT_PERIOD, 32'd1);
        cfg_write(CFG_WD_PERIOD, 32'd1);
        cfg_write(CFG_PANEL_ID, 32'd3);
      end
      1: begin
        cfg_write(CFG_SLOW_TICK, 32'h00FF_FFFF);
        cfg_write(CFG_FAST_TICK, 32'h000F_FFFF);
        cfg_write(CFG_CNT_PERIOD, 32'd255);
        cfg_write(CFG_WD_PERIOD, 32'h00FF_FFFF);
        cfg_write(CFG_PANEL_ID, 32'd7);
      end
      2: begin
        // zero periods behave as one
        cfg_write(CFG_SLOW_TICK, 32'd0);
        cfg_write(CFG_FAST_TICK, 32'd1);
        cfg_write(CFG_CNT_PERIOD, 32'd0);
        cfg_write(CFG_WD_PERIOD, 32'd0);
        cfg_write(CFG_PANEL_ID, 32'd4);
      end
      default: begin
        cfg_write(CFG_SLOW_TICK, 32'd29);
        cfg_write(CFG_FAST_TICK, 32'd13);
        cfg_write(CFG_CNT_PERIOD, 32'd4);
        cfg_write(CFG_WD_PERIOD, 32'd50);
        cfg_write(CFG_PANEL_ID, 32'd2);
      end
    endcase
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report($sformatf("read_data %h, want %h", out_data.read_data, want.read_data));
        if (out_data.irq_vector !== want.irq_vector)
          report($sformatf("irq_vector %h, want %h", out_data.irq_vector, want.irq_vector));
        if (out_data.irq_out !== want.irq_out)
          report($sformatf("irq_out %b, want %b", out_data.irq_out, want.irq_out));
        if (out_data.nmi_out !== want.nmi_out)
          report($sformatf("nmi_out %b, want %b", out_data.nmi_out, want.nmi_out));
        if (out_data.overflow_out !== want.overflow_out)
          report($sformatf("overflow_out %b, want %b", out_data.overflow_out,
                           want.overflow_out));
        if (out_data.write_trapped !== want.write_trapped)
          report($sformatf("write_trapped %b, want %b", out_data.write_trapped,
                           want.write_trapped));
      end
    end
  end

  initial begin : result_sink
    int hold;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int n;
    int seg;
    int k;
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(1, res_of(16'h0000, VEC_BASE, 0, 0, 0), word_of(OP_READ, OFF_STATUS, 0, 0, 0, 0));
    add_row(1, res_of(RD_UNMAPPED, VEC_BASE, 0, 0, 0),
            word_of(OP_READ, OFF_UNMAPPED, 0, 0, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 0, 0), word_of(OP_READ, OFF_COUNTER, 0, 0, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 0, 0),
            word_of(OP_MEMCHK, 0, 0, 20'hFFFFF, 0, 0));
    add_row(0, '0, word_of(OP_WRITE, OFF_PROT_LO, 16'h0010, 0, 0, 0));
    add_row(0, '0, word_of(OP_WRITE, OFF_PROT_HI, 16'h0020, 0, 0, 0));
    add_row(0, '0, word_of(OP_WRITE, OFF_PROTECT | 5'h01, 0, 0, 0, 0));
    // window is 0x102..0x20F
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 1, 1),
            word_of(OP_MEMCHK, 0, 0, 20'h00100, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 1, 1),
            word_of(OP_MEMCHK, 0, 0, 20'h00101, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 1, 0),
            word_of(OP_MEMCHK, 0, 0, 20'h00102, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 1, 1),
            word_of(OP_MEMCHK, 0, 0, 20'h00210, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE, 0, 0, 0),
            word_of(OP_LINE, 0, 0, 0, LINE_EXT_B, 1));
    add_row(1, res_of(16'h0000, VEC_BASE + 7'd2, 1, 0, 0),
            word_of(OP_WRITE, OFF_MASK, 16'h00FF, 0, 0, 0));
    add_row(0, '0, word_of(OP_LINE, 0, 0, 0, LINE_EXT_A, 1));
    add_row(0, '0, word_of(OP_LINE, 0, 0, 0, LINE_EXT_B, 0));
    add_row(0, '0, word_of(OP_LINE, 0, 0, 0, LINE_COMP, 1));
    add_row(1, res_of(16'h0000, VEC_BASE + 7'd3, 1, 1, 0),
            word_of(OP_LINE, 0, 0, 0, LINE_EXT_NMI, 1));
    add_row(1, res_of(ST_EXT_NMI, VEC_BASE + 7'd3, 1, 1, 0),
            word_of(OP_READ, OFF_STATUS, 0, 0, 0, 0));
    add_row(0, '0, word_of(OP_READ, OFF_PENDING, 0, 0, 0, 0));
    add_row(1, res_of(16'h0000, VEC_BASE + 7'd3, 1, 1, 0),
            word_of(OP_READ, OFF_PROTECT, 0, 0, 0, 0));
    add_row(0, '0, word_of(OP_MEMCHK, 0, 0, 20'h00000, 0, 0));
    add_row(0, '0, word_of(OP_LINE, 0, 0, 0, LINE_EXT_NMI, 0));
    add_row(0, '0, word_of(OP_ACK, 5'h1F, 16'hFFFF, 20'hFFFFF, 2'd3, 1));
    add_row(0, '0, word_of(OP_SPARE, 5'h1F, 16'hFFFF, 20'hFFFFF, 2'd3, 1));
    add_row(0, '0, word_of(OP_TICK, 0, 0, 0, 0, 0));
    add_row(0, '0, word_of(OP_WRITE, OFF_UNMAPPED, 16'hFFFF, 0, 0, 0));

    foreach (dir_tab[i]) send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (n = 0; n < 4; n++) begin
      apply_setting(n);
      for (seg = 0; seg < 8; seg++) begin
        calm = ($urandom_range(0, 3) == 0);
        if (seg == 4) drain();
        for (k = 0; k < 53; k++) send_word(rand_word(), 1'b0, '0);
      end
      calm = 1'b0;
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
